// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/kf2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kf2_pkg;
  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_PP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Q_PV      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Q_VV      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR  = 3'd7;

  typedef struct packed {
    logic signed [31:0] measurement;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] est_pos;
    logic signed [31:0] est_vel;
    logic [30:0]        cov_pp;
    logic signed [31:0] cov_pv;
    logic [30:0]        cov_vv;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_item_t;

  // Operations of the shared unit.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NNEG
  } alu_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_DIVFIN
  } alu_state_e;

  // Working register file addresses.
  typedef enum logic [4:0] {
    R_POS, R_VEL, R_VPP, R_VPV, R_VVV,
    R_DT, R_QPP, R_QPV, R_QVV, R_MR, R_Z, R_ONE, R_ZERO,
    R_XP, R_T, R_P00, R_P01, R_P11, R_S, R_K0, R_K1, R_E, R_A,
    R_M00, R_M01, R_M10, R_M11, R_KR0, R_KR1, R_N00, R_N01, R_N11
  } reg_addr_e;

  typedef struct packed {
    alu_op_e   op;
    reg_addr_e a;
    reg_addr_e b;
    reg_addr_e dst;
  } micro_op_t;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } alu_stat_t;

  localparam int unsigned NUM_UOPS = 41;
  localparam int unsigned UPC_W = 6;

  function automatic micro_op_t uop(input logic [UPC_W-1:0] pc);
    micro_op_t u;
    u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
    unique case (pc)
      6'd0:  u = '{OP_MUL, R_DT,  R_VEL, R_XP};
      6'd1:  u = '{OP_ADD, R_POS, R_XP,  R_XP};
      6'd2:  u = '{OP_MUL, R_DT,  R_VVV, R_T};
      6'd3:  u = '{OP_ADD, R_VPV, R_T,   R_T};
      6'd4:  u = '{OP_MUL, R_DT,  R_VPV, R_P00};
      6'd5:  u = '{OP_ADD, R_VPP, R_P00, R_P00};
      6'd6:  u = '{OP_MUL, R_DT,  R_T,   R_P01};
      6'd7:  u = '{OP_ADD, R_P00, R_P01, R_P00};
      6'd8:  u = '{OP_ADD, R_P00, R_QPP, R_P00};
      6'd9:  u = '{OP_ADD, R_T,   R_QPV, R_P01};
      6'd10: u = '{OP_ADD, R_VVV, R_QVV, R_P11};
      6'd11: u = '{OP_ADD, R_P00, R_MR,  R_S};
      6'd12: u = '{OP_DIV, R_P00, R_S,   R_K0};
      6'd13: u = '{OP_DIV, R_P01, R_S,   R_K1};
      6'd14: u = '{OP_SUB, R_Z,   R_XP,  R_E};
      6'd15: u = '{OP_MUL, R_K0,  R_E,   R_POS};
      6'd16: u = '{OP_ADD, R_XP,  R_POS, R_POS};
      6'd17: u = '{OP_MUL, R_K1,  R_E,   R_T};
      6'd18: u = '{OP_ADD, R_VEL, R_T,   R_VEL};
      6'd19: u = '{OP_SUB, R_ONE, R_K0,  R_A};
      6'd20: u = '{OP_MUL, R_A,   R_P00, R_M00};
      6'd21: u = '{OP_MUL, R_A,   R_P01, R_M01};
      6'd22: u = '{OP_MUL, R_K1,  R_P00, R_T};
      6'd23: u = '{OP_SUB, R_P01, R_T,   R_M10};
      6'd24: u = '{OP_MUL, R_K1,  R_P01, R_T};
      6'd25: u = '{OP_SUB, R_P11, R_T,   R_M11};
      6'd26: u = '{OP_MUL, R_A,   R_M00, R_N00};
      6'd27: u = '{OP_MUL, R_K1,  R_M00, R_T};
      6'd28: u = '{OP_SUB, R_M01, R_T,   R_N01};
      6'd29: u = '{OP_MUL, R_K1,  R_M10, R_T};
      6'd30: u = '{OP_SUB, R_M11, R_T,   R_N11};
      6'd31: u = '{OP_MUL, R_K0,  R_MR,  R_KR0};
      6'd32: u = '{OP_MUL, R_K1,  R_MR,  R_KR1};
      6'd33: u = '{OP_MUL, R_KR0, R_K0,  R_T};
      6'd34: u = '{OP_ADD, R_N00, R_T,   R_VPP};
      6'd35: u = '{OP_MUL, R_KR0, R_K1,  R_T};
      6'd36: u = '{OP_ADD, R_N01, R_T,   R_VPV};
      6'd37: u = '{OP_MUL, R_KR1, R_K1,  R_T};
      6'd38: u = '{OP_ADD, R_N11, R_T,   R_VVV};
      6'd39: u = '{OP_NNEG, R_VPP, R_ZERO, R_VPP};
      6'd40: u = '{OP_NNEG, R_VVV, R_ZERO, R_VVV};
      default: u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
    endcase
    return u;
  endfunction

  localparam logic [UPC_W-1:0] LAST_UPC = 6'd40;
endpackage
`default_nettype wire

// ===== rtl/core/kf2_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared arithmetic unit: saturating add/sub, clamp to non-negative, rounded
// Q multiply, and a restoring divider producing one quotient bit a cycle.
module kf2_alu (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire kf2_pkg::alu_cmd_t    cmd_i,
  input  wire logic signed [31:0]   a_i,
  input  wire logic signed [31:0]   b_i,
  output logic signed [31:0]        res_o,
  output kf2_pkg::alu_stat_t        stat_o
);
  import kf2_pkg::*;

  localparam int unsigned QW = DW + FB + 1;   // quotient bits including guard
  localparam int unsigned CW = 6;

  alu_state_e          st_q, st_d;
  logic                neg_q, neg_d;
  logic [63:0]         prod_q, prod_d;
  logic [32:0]         rem_q, rem_d;
  logic [DW+FB-1:0]    num_q, num_d;
  logic [31:0]         den_q, den_d;
  logic [QW-1:0]       quo_q, quo_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic signed [31:0]  res_q, res_d;
  alu_stat_t           stat_q, stat_d;

  logic [31:0] mag_a, mag_b;
  logic signed [32:0] sum;
  logic [48:0] rnd;
  logic [33:0] trial;
  logic [QW-1:0] qr;

  function automatic logic [32:0] satmag(input logic neg, input logic [48:0] m,
                                          output logic o);
    logic [32:0] r;
    o = 1'b0;
    if (neg) begin
      // The magnitude is pinned to 2^31 before the sign is applied, so the
      // negative limit is reached without an overflow.
      if (m > 49'h80000000) r = 33'h1_8000_0000;
      else r = 33'(-m);
    end else begin
      if (m > 49'h7FFFFFFF) begin r = 33'h0_7FFF_FFFF; o = 1'b1; end
      else r = m[32:0];
    end
    return r;
  endfunction

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      A_IDLE: begin
        if (cmd_i.start) begin
          unique case (cmd_i.op)
            OP_MUL:  st_d = A_MUL;
            OP_DIV:  st_d = A_DIV;
            default: st_d = A_IDLE;
          endcase
        end
      end
      A_MUL:    st_d = A_IDLE;
      A_DIV:    if (cnt_q == CW'(1)) st_d = A_DIVFIN;
      A_DIVFIN: st_d = A_IDLE;
      default:  st_d = A_IDLE;
    endcase
  end

  always_comb begin
    logic o;
    logic [32:0] t;
    mag_a = a_i[31] ? 32'(-a_i) : 32'(a_i);
    mag_b = b_i[31] ? 32'(-b_i) : 32'(b_i);
    neg_d = neg_q; prod_d = prod_q; rem_d = rem_q; num_d = num_q;
    den_d = den_q; quo_d = quo_q; cnt_d = cnt_q; res_d = res_q;
    stat_d = '{done: 1'b0, ovf: 1'b0};
    sum = '0; rnd = '0; trial = '0; qr = '0; o = 1'b0; t = '0;
    unique case (st_q)
      A_IDLE: begin
        if (cmd_i.start) begin
          unique case (cmd_i.op)
            OP_ADD, OP_SUB: begin
              sum = (cmd_i.op == OP_ADD) ? (33'(a_i) + 33'(b_i)) : (33'(a_i) - 33'(b_i));
              if (sum > 33'sh7FFFFFFF) begin res_d = 32'h7FFFFFFF; stat_d.ovf = 1'b1; end
              else if (sum < -33'sh80000000) begin
                res_d = 32'h80000000; stat_d.ovf = 1'b1;
              end else res_d = sum[31:0];
              stat_d.done = 1'b1;
            end
            OP_NNEG: begin
              if (a_i[31]) begin res_d = '0; stat_d.ovf = 1'b1; end
              else res_d = a_i;
              stat_d.done = 1'b1;
            end
            OP_MUL: begin
              neg_d = a_i[31] ^ b_i[31];
              prod_d = mag_a * mag_b;
            end
            OP_DIV: begin
              // The divisor is nonzero positive here; S <= 0 is handled outside.
              neg_d = a_i[31];
              num_d = {mag_a, {FB{1'b0}}};
              den_d = b_i;
              rem_d = '0;
              quo_d = '0;
              cnt_d = CW'(DW + FB);
            end
            default: stat_d.done = 1'b1;
          endcase
        end
      end
      A_MUL: begin
        rnd = 49'((prod_q + 64'(1 << (FB - 1))) >> FB);
        t = satmag(neg_q, rnd, o);
        res_d = t[31:0];
        stat_d = '{done: 1'b1, ovf: o};
      end
      A_DIV: begin
        // Restoring division, one quotient bit per cycle.
        trial = {rem_q, num_q[DW+FB-1]} - {2'b0, den_q};
        num_d = {num_q[DW+FB-2:0], 1'b0};
        if (!trial[33]) begin
          rem_d = trial[32:0];
          quo_d = {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[31:0], num_q[DW+FB-1]};
          quo_d = {quo_q[QW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
      A_DIVFIN: begin
        // Round to nearest: add one when 2*rem >= den (ties away from zero).
        qr = quo_q + QW'(({rem_q, 1'b0} >= {2'b0, den_q}) ? 1 : 0);
        t = satmag(neg_q, 49'(qr), o);
        res_d = t[31:0];
        stat_d = '{done: 1'b1, ovf: o};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= A_IDLE;
      stat_q <= '0;
    end else begin
      st_q <= st_d;
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; prod_q <= prod_d; rem_q <= rem_d; num_q <= num_d;
    den_q <= den_d; quo_q <= quo_d; cnt_q <= cnt_d; res_q <= res_d;
  end

  assign res_o = res_q;
  assign stat_o = stat_q;
endmodule
`default_nettype wire

// ===== rtl/core/kalman_filter_two_state_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-state constant-velocity Kalman filter in Q16.16. Each accepted
// measurement runs 41 micro-operations through one shared arithmetic unit:
// add, subtract and clamp, multiplies, and two divisions that produce one
// quotient bit per cycle. Both divisions are skipped, with zero results, when
// the innovation variance is not positive. The input is not ready while a step
// runs or while the result waits in the output register for its transfer.
// The user must write configuration through the cfg channel only while the
// block is idle; the block itself does not enforce this.
module kalman_filter_two_state_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire kf2_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output kf2_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire kf2_pkg::cfg_item_t cfg_data_i
);
  import kf2_pkg::*;
  `include "assert_macros.svh"

  logic signed [31:0] rf_q [32];
  logic signed [31:0] rf_d [32];
  seq_state_e st_q, st_d;
  logic [UPC_W-1:0] pc_q, pc_d;
  logic ovf_q, ovf_d;
  logic ov_q, ov_d;
  out_item_t out_q;
  micro_op_t u;
  alu_cmd_t cmd;
  alu_stat_t stat;
  logic signed [31:0] alu_res;
  logic skip_div;
  logic signed [31:0] init_pos_q, init_vel_q, init_var_q;

  function automatic logic signed [31:0] rf_init(input reg_addr_e ra);
    logic signed [31:0] v;
    unique case (ra)
      R_VEL:        v = 32'sd32768;
      R_VPP, R_VVV: v = 32'sd655360;
      R_DT:         v = 32'sd6554;
      R_QPP:        v = 32'sd1;
      R_QPV:        v = 32'sd26;
      R_QVV:        v = 32'sd524;
      R_MR:         v = 32'sd26214;
      R_ONE:        v = 32'sd1 <<< FB;
      default:      v = '0;
    endcase
    return v;
  endfunction

  assign u = uop(pc_q);
  assign skip_div = (u.op == OP_DIV) && (rf_q[R_S] <= 0);

  kf2_alu u_alu (
    .clk_i, .rst_ni, .cmd_i(cmd), .a_i(rf_q[u.a]), .b_i(rf_q[u.b]),
    .res_o(alu_res), .stat_o(stat)
  );

  assign in_ready_o = (st_q == ST_IDLE) && !ov_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  always_comb begin
    st_d = st_q;
    pc_d = pc_q;
    unique case (st_q)
      ST_IDLE:  if (in_valid_i && in_ready_o) st_d = ST_ISSUE;
      ST_ISSUE: st_d = skip_div ? ((pc_q == LAST_UPC) ? ST_DONE : ST_ISSUE) : ST_WAIT;
      ST_WAIT:  if (stat.done) st_d = (pc_q == LAST_UPC) ? ST_DONE : ST_ISSUE;
      ST_DONE:  st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
    if (st_q == ST_IDLE) pc_d = '0;
    else if ((st_q == ST_ISSUE && skip_div) || (st_q == ST_WAIT && stat.done))
      pc_d = pc_q + 1'b1;
  end

  always_comb begin
    cmd = '{start: (st_q == ST_ISSUE) && !skip_div, op: u.op};
    rf_d = rf_q;
    ovf_d = ovf_q;
    ov_d = ov_q && !out_ready_i;
    rf_d[R_ONE] = 32'sd1 <<< FB;
    rf_d[R_ZERO] = '0;
    if (cfg_valid_i) begin
      unique case (cfg_data_i.index)
        REG_TIME_STEP: rf_d[R_DT]  = {1'b0, cfg_data_i.data[30:0]};
        REG_Q_PP:      rf_d[R_QPP] = {1'b0, cfg_data_i.data[30:0]};
        REG_Q_PV:      rf_d[R_QPV] = cfg_data_i.data;
        REG_Q_VV:      rf_d[R_QVV] = {1'b0, cfg_data_i.data[30:0]};
        REG_R:         rf_d[R_MR]  = {1'b0, cfg_data_i.data[30:0]};
        REG_INIT_POS, REG_INIT_VEL, REG_INIT_VAR: ;
        default: ;
      endcase
    end
    if (st_q == ST_IDLE && in_valid_i && in_ready_o) begin
      rf_d[R_Z] = in_data_i.measurement;
      ovf_d = 1'b0;
      // Restart loads from the shadow init registers.
      if (in_data_i.restart) begin
        rf_d[R_POS] = init_pos_q;
        rf_d[R_VEL] = init_vel_q;
        rf_d[R_VPP] = init_var_q;
        rf_d[R_VPV] = '0;
        rf_d[R_VVV] = init_var_q;
      end
    end
    if (st_q == ST_ISSUE && skip_div) rf_d[u.dst] = '0;
    if (st_q == ST_WAIT && stat.done) begin
      rf_d[u.dst] = alu_res;
      ovf_d = ovf_q | stat.ovf;
    end
    if (st_q == ST_DONE) ov_d = 1'b1;
  end

  // Init values live in a shadow set so temporaries never overwrite them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_pos_q <= '0; init_vel_q <= 32'sd32768; init_var_q <= 32'sd655360;
    end else if (cfg_valid_i) begin
      if (cfg_data_i.index == REG_INIT_POS) init_pos_q <= cfg_data_i.data;
      if (cfg_data_i.index == REG_INIT_VEL) init_vel_q <= cfg_data_i.data;
      if (cfg_data_i.index == REG_INIT_VAR) init_var_q <= {1'b0, cfg_data_i.data[30:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      pc_q <= '0;
      ovf_q <= 1'b0;
      ov_q <= 1'b0;
      for (int i = 0; i < 32; i++) rf_q[i] <= rf_init(reg_addr_e'(5'(i)));
    end else begin
      st_q <= st_d;
      pc_q <= pc_d;
      ovf_q <= ovf_d;
      ov_q <= ov_d;
      for (int i = 0; i < 32; i++) rf_q[i] <= rf_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DONE) begin
      out_q.est_pos  <= rf_q[R_POS];
      out_q.est_vel  <= rf_q[R_VEL];
      out_q.cov_pp   <= rf_q[R_VPP][30:0];
      out_q.cov_pv   <= rf_q[R_VPV];
      out_q.cov_vv   <= rf_q[R_VVV][30:0];
      out_q.overflow <= ovf_q;
    end
  end

  `ASSERT_IMPL(a_busy_not_ready, clk_i, rst_ni, (st_q != ST_IDLE) |-> !in_ready_o, "ready while busy")
  `ASSERT_IMPL(a_done_valid, clk_i, rst_ni, (st_q == ST_DONE) |=> out_valid_o, "result not shown")
  `ASSERT_IMPL(a_cov_nonneg, clk_i, rst_ni, out_valid_o |-> !rf_q[R_VPP][31], "negative variance")
endmodule
`default_nettype wire
